>>> sv/pqx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqx_pkg
// shared types and codes for the primitive to quad expander
// ----------------------------------------------------------------------------
package pqx_pkg;

   localparam int CoordW = 24;
   localparam int ColorW = 8;
   localparam int EdgeW  = 16;

   localparam logic [EdgeW-1:0] EDGE_RESET = 16'd256;

   // primitive type codes on the request
   localparam logic [2:0] FUNC_POINT    = 3'd0;
   localparam logic [2:0] FUNC_LINE     = 3'd1;
   localparam logic [2:0] FUNC_SPRITE   = 3'd2;
   localparam logic [2:0] FUNC_TRIANGLE = 3'd3;
   localparam logic [2:0] FUNC_QUAD     = 3'd4;

   localparam logic [2:0] TRIANGLE_VERTS = 3'd3;
   localparam logic [2:0] QUAD_VERTS     = 3'd6;

   // how a queued frame is expanded
   localparam logic [1:0] KIND_PASS   = 2'd0;
   localparam logic [1:0] KIND_POINT  = 2'd1;
   localparam logic [1:0] KIND_LINE   = 2'd2;
   localparam logic [1:0] KIND_SPRITE = 2'd3;

   localparam logic [2:0] LAST_CORNER = 3'd5;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic [ColorW-1:0]        r;
      logic [ColorW-1:0]        g;
      logic [ColorW-1:0]        b;
      logic [ColorW-1:0]        a;
      logic signed [CoordW-1:0] u;
      logic signed [CoordW-1:0] v;
   } vertex_type;

   typedef struct packed {
      logic [1:0] kind;
      vertex_type va;
      vertex_type vb;
      logic       horiz;
      logic       last;
   } frame_type;

endpackage

>>> sv/pqx_collect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqx_collect
// primitive tracking: held first vertex, vertex count, frame build
// ----------------------------------------------------------------------------
module pqx_collect (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [2:0]         func,
   input  pqx_pkg::vertex_type cur,
   output pqx_pkg::frame_type  frame_in,
   output logic               frame_load
);
   import pqx_pkg::*;

   vertex_type held_ff;
   logic [2:0] count_ff, count_in;
   logic [2:0] type_ff;
   logic [2:0] eff_count;
   logic       hold_now;
   logic signed [CoordW:0] dx, dy;
   logic [CoordW:0] adx, ady;

   assign eff_count = (count_ff != 3'd0 && func != type_ff) ? 3'd0 : count_ff;

   // major axis of the line, held vertex to current
   assign dx  = {cur.x[CoordW-1], cur.x} - {held_ff.x[CoordW-1], held_ff.x};
   assign dy  = {cur.y[CoordW-1], cur.y} - {held_ff.y[CoordW-1], held_ff.y};
   assign adx = dx[CoordW] ? -dx : dx;
   assign ady = dy[CoordW] ? -dy : dy;

   always_comb begin
      frame_in       = '0;
      frame_in.va    = cur;
      frame_in.vb    = cur;
      frame_in.horiz = adx > ady;
      frame_load     = 1'b0;
      hold_now       = 1'b0;
      count_in       = 3'd0;
      case (func)
         FUNC_TRIANGLE, FUNC_QUAD: begin
            frame_in.kind = KIND_PASS;
            frame_in.last = (3'(eff_count + 3'd1) >=
                             ((func == FUNC_TRIANGLE) ? TRIANGLE_VERTS : QUAD_VERTS));
            frame_load    = 1'b1;
            count_in      = frame_in.last ? 3'd0 : 3'(eff_count + 3'd1);
         end
         FUNC_POINT: begin
            frame_in.kind = KIND_POINT;
            frame_load    = 1'b1;
         end
         FUNC_LINE, FUNC_SPRITE: begin
            frame_in.kind = (func == FUNC_LINE) ? KIND_LINE : KIND_SPRITE;
            frame_in.va   = held_ff;
            if (eff_count == 3'd0) begin
               hold_now = 1'b1;
               count_in = 3'd1;
            end else begin
               frame_load = 1'b1;
            end
         end
         default: begin
            // invalid type, partial primitive dropped
            count_in = 3'd0;
         end
      endcase
      frame_load = frame_load & take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         type_ff  <= FUNC_POINT;
      end else if (take) begin
         count_ff <= count_in;
         if (func <= FUNC_QUAD) begin
            type_ff <= func;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && hold_now) begin
         held_ff <= cur;
      end
   end

endmodule

>>> sv/pqx_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqx_emit
// frame register, corner sequencer and response register
// ----------------------------------------------------------------------------
module pqx_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [pqx_pkg::EdgeW-1:0] csr_edge_thickness,
   input  logic               frame_load,
   input  pqx_pkg::frame_type  frame_in,
   input  logic               rsp_stall,
   output logic               frame_free,
   output logic               rsp_valid,
   output pqx_pkg::vertex_type rsp_vertex,
   output logic               rsp_eop
);
   import pqx_pkg::*;

   typedef struct packed {
      logic sel_b;
      logic b_xu;
      logic b_yv;
      logic add_x;
      logic add_y;
   } corner_type;

   logic [EdgeW-1:0] edge_ff;
   frame_type        frame_ff;
   logic             frame_valid_ff;
   logic [2:0]       idx_ff;
   vertex_type       out_ff, out_in;
   logic             out_valid_ff;
   logic             eop_ff, eop_in;
   logic             out_load, emit_now, frame_last;
   corner_type       ctl;

   function automatic logic signed [CoordW-1:0] add_sat(
      input logic signed [CoordW-1:0] c,
      input logic [EdgeW-1:0]         w
   );
      logic signed [CoordW:0] s;
      s = {c[CoordW-1], c} + {{(CoordW+1-EdgeW){1'b0}}, w};
      if (s[CoordW:CoordW-1] == 2'b01) begin
         add_sat = {1'b0, {(CoordW-1){1'b1}}};
      end else if (s[CoordW:CoordW-1] == 2'b10) begin
         add_sat = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
         add_sat = s[CoordW-1:0];
      end
   endfunction

   function automatic corner_type corner_ctl(
      input logic [1:0] kind,
      input logic [2:0] idx,
      input logic       horiz
   );
      logic grp_a, grp_b;
      corner_type c;
      grp_a = (idx == 3'd1) || (idx == 3'd4) || (idx == 3'd5);
      grp_b = (idx == 3'd2) || (idx == 3'd3) || (idx == 3'd5);
      c = '0;
      case (kind)
         KIND_POINT: begin
            c.add_x = grp_b;
            c.add_y = grp_a;
         end
         KIND_LINE: begin
            c.sel_b = grp_b;
            c.add_x = grp_a & ~horiz;
            c.add_y = grp_a & horiz;
         end
         KIND_SPRITE: begin
            c.b_xu = grp_a;
            c.b_yv = grp_b;
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

   assign out_load   = !out_valid_ff || !rsp_stall;
   assign emit_now   = frame_valid_ff && out_load;
   assign frame_last = (frame_ff.kind == KIND_PASS) || (idx_ff == LAST_CORNER);
   assign frame_free = !frame_valid_ff || (emit_now && frame_last);
   assign ctl        = corner_ctl(frame_ff.kind, idx_ff, frame_ff.horiz);

   always_comb begin
      out_in = ctl.sel_b ? frame_ff.vb : frame_ff.va;
      if (ctl.b_xu) begin
         out_in.x = frame_ff.vb.x;
         out_in.u = frame_ff.vb.u;
      end
      if (ctl.b_yv) begin
         out_in.y = frame_ff.vb.y;
         out_in.v = frame_ff.vb.v;
      end
      if (ctl.add_x) begin
         out_in.x = add_sat(out_in.x, edge_ff);
      end
      if (ctl.add_y) begin
         out_in.y = add_sat(out_in.y, edge_ff);
      end
      eop_in = (frame_ff.kind == KIND_PASS) ? frame_ff.last : (idx_ff == LAST_CORNER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff        <= EDGE_RESET;
         frame_valid_ff <= 1'b0;
         idx_ff         <= 3'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            edge_ff <= csr_edge_thickness;
         end
         if (frame_load) begin
            frame_valid_ff <= 1'b1;
            idx_ff         <= 3'd0;
         end else if (emit_now && frame_last) begin
            frame_valid_ff <= 1'b0;
         end else if (emit_now) begin
            idx_ff <= 3'(idx_ff + 3'd1);
         end
         if (out_load) begin
            out_valid_ff <= frame_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_load) begin
         frame_ff <= frame_in;
      end
      if (emit_now) begin
         out_ff <= out_in;
         eop_ff <= eop_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_vertex = out_ff;
   assign rsp_eop    = eop_ff;

endmodule

>>> sv/primitive_to_quad_expander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_to_quad_expander
// expands points, lines and sprites into two-triangle, six-vertex primitives
// ----------------------------------------------------------------------------
// One request is one vertex tagged with a primitive type. Triangle and quad
// vertices pass one for one, one vertex per cycle unless the response stalls.
// A point, or the second vertex of a line or sprite, queues a frame that the
// response register drains as six vertices, one per cycle unless stalled, and
// the request side stalls meanwhile; the response register is the single
// output port and sets that rate. The first vertex of a line or sprite and a
// request of invalid type are taken and give no response. A response passes
// the frame register, then the response register. The next request is taken
// in the same cycle that the last vertex of the current frame moves
// to the response register. edge_thickness is written through the csr port
// (always ready) and should only change while no request is in flight.
module primitive_to_quad_expander (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [15:0]              csr_edge_thickness,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_func,
   input  logic signed [23:0]       req_pos_x,
   input  logic signed [23:0]       req_pos_y,
   input  logic signed [23:0]       req_pos_z,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,
   input  logic [7:0]               req_alpha,
   input  logic signed [23:0]       req_tex_u,
   input  logic signed [23:0]       req_tex_v,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [23:0]       rsp_out_x,
   output logic signed [23:0]       rsp_out_y,
   output logic signed [23:0]       rsp_out_z,
   output logic [7:0]               rsp_out_red,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_blue,
   output logic [7:0]               rsp_out_alpha,
   output logic signed [23:0]       rsp_out_u,
   output logic signed [23:0]       rsp_out_v,
   output logic                     rsp_end_of_primitive
);
   import pqx_pkg::*;

   vertex_type cur;
   vertex_type rsp_vertex;
   frame_type  frame_in;
   logic       frame_load;
   logic       frame_free;
   logic       take;

   // pack the request vertex
   always_comb begin
      cur.x = req_pos_x;
      cur.y = req_pos_y;
      cur.z = req_pos_z;
      cur.r = req_red;
      cur.g = req_green;
      cur.b = req_blue;
      cur.a = req_alpha;
      cur.u = req_tex_u;
      cur.v = req_tex_v;
   end

   // a request is taken whenever the frame register is free or its last vertex moves on
   assign req_stall = !frame_free;
   assign take      = req_valid && frame_free;
   assign csr_ready = 1'b1;

   // primitive tracking and frame build
   pqx_collect u_collect (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .func       (req_func),
      .cur        (cur),
      .frame_in   (frame_in),
      .frame_load (frame_load)
   );

   // corner sequencer and response register
   pqx_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_edge_thickness (csr_edge_thickness),
      .frame_load         (frame_load),
      .frame_in           (frame_in),
      .rsp_stall          (rsp_stall),
      .frame_free         (frame_free),
      .rsp_valid          (rsp_valid),
      .rsp_vertex         (rsp_vertex),
      .rsp_eop            (rsp_end_of_primitive)
   );

   // unpack the response vertex
   assign rsp_out_x     = rsp_vertex.x;
   assign rsp_out_y     = rsp_vertex.y;
   assign rsp_out_z     = rsp_vertex.z;
   assign rsp_out_red   = rsp_vertex.r;
   assign rsp_out_green = rsp_vertex.g;
   assign rsp_out_blue  = rsp_vertex.b;
   assign rsp_out_alpha = rsp_vertex.a;
   assign rsp_out_u     = rsp_vertex.u;
   assign rsp_out_v     = rsp_vertex.v;

endmodule

>>> sv/pqx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqx_checker
// port-level checks for the primitive to quad expander
// ----------------------------------------------------------------------------
module pqx_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [23:0] rsp_out_x,
   input logic signed [23:0] rsp_out_y,
   input logic               rsp_end_of_primitive
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its x, y and end-of-primitive
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_x) && $stable(rsp_out_y)
                                 && $stable(rsp_end_of_primitive))
      else $error("response payload changed while stalled");

   // after reset nothing is pending and requests are open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // a stalled request means a frame is queued, so a taken response is followed
   a_frame_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && req_stall |=> rsp_valid)
      else $error("queued frame did not advance");

endmodule

bind primitive_to_quad_expander pqx_checker u_pqx_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_out_x            (rsp_out_x),
   .rsp_out_y            (rsp_out_y),
   .rsp_end_of_primitive (rsp_end_of_primitive)
);
